### design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the RTL files.
// Each macro samples on the rising edge of clk and is off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AST_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define AST_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/iou_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iou_pkg
// Widths, payload types and the span overlap helper of the box IoU block.
// ---------------------------------------------------------------------------
package iou_pkg;

    localparam int COORD_BITS  = 12;
    localparam int FRAC_BITS   = 16;
    localparam int AREA_BITS   = 2 * COORD_BITS;
    localparam int UNI_BITS    = AREA_BITS + 1;
    localparam int QUO_BITS    = FRAC_BITS + 1;
    localparam int DIV_STEPS   = QUO_BITS;
    localparam int PIPE_STAGES = 3 + DIV_STEPS;

    localparam logic [QUO_BITS-1:0] RATIO_ONE = QUO_BITS'(1) << FRAC_BITS;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t a_left;
        coord_t a_top;
        coord_t a_width;
        coord_t a_height;
        coord_t b_left;
        coord_t b_top;
        coord_t b_width;
        coord_t b_height;
    } iou_req_t;

    typedef struct packed {
        logic [QUO_BITS-1:0] ratio;
        logic                empty_union;
    } iou_rsp_t;

    // Overlap of [lo_a, lo_a+len_a) and [lo_b, lo_b+len_b), clamped at zero.
    function automatic coord_t span_overlap(
        input coord_t lo_a,
        input coord_t len_a,
        input coord_t lo_b,
        input coord_t len_b
    );
        logic [COORD_BITS:0] hi_a;
        logic [COORD_BITS:0] hi_b;
        logic [COORD_BITS:0] lo;
        logic [COORD_BITS:0] hi;
        logic [COORD_BITS:0] diff;
        hi_a = {1'b0, lo_a} + {1'b0, len_a};
        hi_b = {1'b0, lo_b} + {1'b0, len_b};
        lo   = (lo_a > lo_b) ? {1'b0, lo_a} : {1'b0, lo_b};
        hi   = (hi_a < hi_b) ? hi_a : hi_b;
        diff = (hi > lo) ? (hi - lo) : '0;
        return diff[COORD_BITS-1:0];
    endfunction

endpackage

### design/box_intersection_over_union.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// box_intersection_over_union
// Pipelined intersection over union of two axis-aligned boxes.
// ---------------------------------------------------------------------------
// Usage:
//   A request carries two boxes (left, top, width, height each) on req and is
//   taken at a rising edge where req_valid is high and req_stall is low. Each
//   request gives exactly one response on rsp: ratio = floor(overlap * 2^16 /
//   union) with 2^16 meaning 1.0, and empty_union set (ratio 0) when both
//   boxes have zero area. Edges are exclusive on the right and bottom.
//   The pipe is three arithmetic stages (overlap and areas, intersection and
//   area sum, union) followed by a 17-stage restoring divider that retires
//   one quotient bit per stage. It takes one request per cycle while
//   req_stall is low.
//   Every stage owns a valid bit. A stage advances when it is empty or its
//   successor advances, so a stalled response holds in the last stage while
//   bubbles further up still fill; req_stall rises only once the pipe is full
//   back to the entry stage. Reset clears all valid bits and no response is
//   shown until a request has been accepted.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module box_intersection_over_union
    import iou_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  iou_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output iou_rsp_t rsp
);

    // Valid bit of each stage and the advance chain (top bit is the consumer).
    logic [PIPE_STAGES-1:0] vld_reg;
    logic [PIPE_STAGES:0]   adv;

    // Stage 0: overlap extents and both areas.
    coord_t                 ow_reg;
    coord_t                 oh_reg;
    logic [AREA_BITS-1:0]   area_a_reg;
    logic [AREA_BITS-1:0]   area_b_reg;

    // Stage 1: intersection area and sum of the two areas.
    logic [AREA_BITS-1:0]   inter_reg;
    logic [UNI_BITS-1:0]    sum_reg;

    // Divider: entry 0 is the setup stage, entries 1..DIV_STEPS retire one
    // quotient bit each.
    logic [UNI_BITS-1:0]    dv_rem_reg  [DIV_STEPS+1];
    logic [UNI_BITS-1:0]    dv_uni_reg  [DIV_STEPS+1];
    logic [QUO_BITS-1:0]    dv_quo_reg  [DIV_STEPS+1];
    logic                   dv_emp_reg  [DIV_STEPS+1];
    logic [UNI_BITS-1:0]    dv_rem_next [DIV_STEPS+1];
    logic [QUO_BITS-1:0]    dv_quo_next [DIV_STEPS+1];
    logic                   lsb_reg;

    logic [UNI_BITS-1:0]    uni_next;

    // Last stage holds a real quotient (valid and nonzero union).
    logic                   out_live;
    logic                   rem_ok;

    // ------------------------------------------------------------------
    // Advance chain: a stage moves when it is empty or the next one moves.
    // ------------------------------------------------------------------
    always_comb
    begin
        adv[PIPE_STAGES] = !rsp_stall;
        for (int k = PIPE_STAGES - 1; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign req_stall = !adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= req_valid;
            end
            for (int k = 1; k < PIPE_STAGES; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 0 and 1: overlap, areas, intersection, area sum.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            ow_reg     <= span_overlap(req.a_left, req.a_width, req.b_left, req.b_width);
            oh_reg     <= span_overlap(req.a_top, req.a_height, req.b_top, req.b_height);
            area_a_reg <= AREA_BITS'(req.a_width) * AREA_BITS'(req.a_height);
            area_b_reg <= AREA_BITS'(req.b_width) * AREA_BITS'(req.b_height);
        end
        if (adv[1])
        begin
            inter_reg <= AREA_BITS'(ow_reg) * AREA_BITS'(oh_reg);
            sum_reg   <= {1'b0, area_a_reg} + {1'b0, area_b_reg};
        end
    end

    // Union never goes negative: the intersection is part of each area.
    assign uni_next = sum_reg - {1'b0, inter_reg};

    // ------------------------------------------------------------------
    // Restoring divider. The dividend is inter * 2^FRAC_BITS, so the
    // partial remainder starts at inter >> 1 (below the union), the first
    // step brings down the intersection's low bit and later steps a zero.
    // ------------------------------------------------------------------
    always_comb
    begin
        logic                bit_in;
        logic [UNI_BITS:0]   trial;
        logic [UNI_BITS:0]   diff;
        logic                ge;
        dv_rem_next[0] = '0;
        dv_quo_next[0] = '0;
        for (int d = 1; d <= DIV_STEPS; d++)
        begin
            bit_in         = (d == 1) ? lsb_reg : 1'b0;
            trial          = {dv_rem_reg[d-1], bit_in};
            diff           = trial - {1'b0, dv_uni_reg[d-1]};
            ge             = (trial >= {1'b0, dv_uni_reg[d-1]});
            dv_rem_next[d] = ge ? diff[UNI_BITS-1:0] : trial[UNI_BITS-1:0];
            dv_quo_next[d] = {dv_quo_reg[d-1][QUO_BITS-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            dv_rem_reg[0] <= UNI_BITS'(inter_reg >> 1);
            dv_uni_reg[0] <= uni_next;
            dv_quo_reg[0] <= '0;
            dv_emp_reg[0] <= (uni_next == '0);
            lsb_reg       <= inter_reg[0];
        end
        for (int d = 1; d <= DIV_STEPS; d++)
        begin
            if (adv[d+2])
            begin
                dv_rem_reg[d] <= dv_rem_next[d];
                dv_uni_reg[d] <= dv_uni_reg[d-1];
                dv_quo_reg[d] <= dv_quo_next[d];
                dv_emp_reg[d] <= dv_emp_reg[d-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Response: the last divider stage is the output register. Force the
    // ratio to zero on an empty union.
    // ------------------------------------------------------------------
    assign rsp_valid       = vld_reg[PIPE_STAGES-1];
    assign rsp.ratio       = dv_emp_reg[DIV_STEPS] ? '0 : dv_quo_reg[DIV_STEPS];
    assign rsp.empty_union = dv_emp_reg[DIV_STEPS];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    assign out_live = vld_reg[PIPE_STAGES-1] && !dv_emp_reg[DIV_STEPS];
    assign rem_ok   = (dv_rem_reg[DIV_STEPS] < dv_uni_reg[DIV_STEPS]);

    `AST_IMPLIES(a_ratio_bound, out_live, dv_quo_reg[DIV_STEPS] <= RATIO_ONE, "ratio above one")
    `AST_IMPLIES(a_rem_below_union, out_live, rem_ok, "remainder not below union")
    `AST_NEXT(a_accept_loads, req_valid && !req_stall, vld_reg[0], "request not captured")
    `AST_NEXT(a_hold_on_stall, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "response lost")

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pipelined box intersection over union block.
// Requests are queued by an initial block and handed to a clocked driver with
// random idle bursts. A clocked monitor applies random stall bursts and
// checks every response, in order, against a scoreboard of predicted
// ratio and empty_union values worked out when each request is accepted.
// ---------------------------------------------------------------------------
module tb_top;
    import iou_pkg::*;

    localparam int RANDOM_REQS = 1530;
    localparam int CALM_TAIL   = 150;      // last requests run with no idling
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = PIPE_STAGES + 10;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_stall;
    iou_req_t req       = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    iou_rsp_t rsp;

    iou_req_t    req_backlog[$];   // requests still to be driven
    iou_rsp_t    scores_due[$];    // predicted responses, oldest first
    int unsigned fail_count   = 0;
    int unsigned cycle_count  = 0;
    int unsigned req_idle_pct = 0;
    int unsigned rsp_idle_pct = 0;
    int unsigned send_gap     = 0;
    int unsigned stall_left   = 0;

    box_intersection_over_union dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #2 clk = ~clk;

    // -----------------------------------------------------------------------
    // Prediction
    // -----------------------------------------------------------------------

    // Length shared by [lo_a, lo_a+len_a) and [lo_b, lo_b+len_b).
    // Ends are one bit wider than the coordinates so they never wrap.
    function automatic logic [COORD_BITS:0] shared_extent(
        input coord_t lo_a,
        input coord_t len_a,
        input coord_t lo_b,
        input coord_t len_b
    );
        logic [COORD_BITS:0] end_a;
        logic [COORD_BITS:0] end_b;
        logic [COORD_BITS:0] start;
        logic [COORD_BITS:0] stop;
        end_a = {1'b0, lo_a} + {1'b0, len_a};
        end_b = {1'b0, lo_b} + {1'b0, len_b};
        start = (lo_a > lo_b) ? {1'b0, lo_a} : {1'b0, lo_b};
        stop  = (end_a < end_b) ? end_a : end_b;
        return (stop > start) ? (stop - start) : '0;
    endfunction

    // Ratio = floor(overlap * 2^FRAC_BITS / union); zero union raises the flag.
    function automatic iou_rsp_t predict_iou(input iou_req_t r);
        logic [COORD_BITS:0] span_x;
        logic [COORD_BITS:0] span_y;
        logic [63:0]         overlap_area;
        logic [63:0]         union_area;
        iou_rsp_t            want;
        span_x = shared_extent(r.a_left, r.a_width, r.b_left, r.b_width);
        span_y = shared_extent(r.a_top, r.a_height, r.b_top, r.b_height);
        overlap_area = 64'(span_x) * 64'(span_y);
        union_area   = 64'(r.a_width) * 64'(r.a_height)
                     + 64'(r.b_width) * 64'(r.b_height) - overlap_area;
        want = '0;
        if (union_area == 64'd0)
        begin
            want.empty_union = 1'b1;
        end
        else
        begin
            want.ratio = QUO_BITS'((overlap_area << FRAC_BITS) / union_area);
        end
        return want;
    endfunction

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------

    function automatic iou_req_t box_pair(
        input int al, input int at, input int aw, input int ah,
        input int bl, input int bt, input int bw, input int bh
    );
        iou_req_t r;
        r.a_left   = coord_t'(al);
        r.a_top    = coord_t'(at);
        r.a_width  = coord_t'(aw);
        r.a_height = coord_t'(ah);
        r.b_left   = coord_t'(bl);
        r.b_top    = coord_t'(bt);
        r.b_width  = coord_t'(bw);
        r.b_height = coord_t'(bh);
        return r;
    endfunction

    // Mostly small boxes, with a tail reaching the full coordinate range.
    function automatic coord_t rand_extent();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return coord_t'($urandom_range(0, 64));
        else if (pick < 90)
            return coord_t'($urandom_range(0, 1023));
        else
            return coord_t'($urandom_range(0, 4095));
    endfunction

    // Count a mismatch and print one line for it.
    task automatic report_mismatch(input string what, input int got, input int want);
        fail_count++;
        $display("[%0t] MISMATCH %s: got %0d, want %0d", $time, what, got, want);
    endtask

    // -----------------------------------------------------------------------
    // Cycle counter, idle-rate mode changes and the timeout
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        // Reroll how busy each side is, so calm stretches alternate with
        // heavy idling and gaps land on every pipeline phase.
        if (cycle_count % 128 == 0)
        begin
            case ($urandom_range(2))
                0:       req_idle_pct <= 0;
                1:       req_idle_pct <= 15;
                default: req_idle_pct <= 50;
            endcase
            case ($urandom_range(2))
                0:       rsp_idle_pct <= 0;
                1:       rsp_idle_pct <= 15;
                default: rsp_idle_pct <= 50;
            endcase
        end
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Driver: hold a stalled request, otherwise idle or load the next one
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // Predict at the accepting edge, from the payload being taken.
            if (req_valid && !req_stall)
                scores_due.push_back(predict_iou(req));

            if (!req_valid || !req_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    req_valid <= 1'b0;
                end
                else if (req_backlog.size() >= CALM_TAIL &&
                         $urandom_range(99) < req_idle_pct)
                begin
                    // This cycle is the first of an idle burst.
                    send_gap <= $urandom_range(0, 8);
                    req_valid <= 1'b0;
                end
                else if (req_backlog.size() != 0)
                begin
                    req <= req_backlog.pop_front();
                    req_valid <= 1'b1;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Monitor: check each accepted response, then pick the next stall value
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (scores_due.size() == 0)
                begin
                    report_mismatch("response with no request pending", 1, 0);
                end
                else
                begin
                    iou_rsp_t want;
                    want = scores_due.pop_front();
                    if (rsp.ratio !== want.ratio)
                        report_mismatch("ratio", rsp.ratio, want.ratio);
                    if (rsp.empty_union !== want.empty_union)
                        report_mismatch("empty_union", rsp.empty_union, want.empty_union);
                end
            end

            // Stall independently of rsp_valid; drop stalls in the calm tail.
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                rsp_stall <= 1'b1;
            end
            else if (req_backlog.size() >= CALM_TAIL &&
                     $urandom_range(99) < rsp_idle_pct)
            begin
                stall_left <= $urandom_range(0, 8);
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= 1'b0;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Fill the backlog, release reset, wait for the drain and decide
    // -----------------------------------------------------------------------
    initial
    begin
        iou_req_t r;
        int unsigned kind;

        // Directed requests: extremes and named corner cases.
        req_backlog.push_back(box_pair(0, 0, 0, 0, 0, 0, 0, 0));          // empty union
        req_backlog.push_back(box_pair(4095, 4095, 4095, 4095,
                                       4095, 4095, 4095, 4095));         // max, identical
        req_backlog.push_back(box_pair(10, 20, 30, 40, 10, 20, 30, 40));  // ratio of one
        req_backlog.push_back(box_pair(0, 0, 10, 10, 100, 100, 10, 10));  // disjoint
        req_backlog.push_back(box_pair(0, 0, 10, 10, 10, 0, 10, 10));     // touch in x
        req_backlog.push_back(box_pair(0, 0, 10, 10, 0, 10, 10, 10));     // touch in y
        req_backlog.push_back(box_pair(0, 0, 100, 100, 10, 10, 10, 10));  // b inside a
        req_backlog.push_back(box_pair(10, 10, 10, 10, 0, 0, 100, 100));  // a inside b
        req_backlog.push_back(box_pair(0, 0, 10, 10, 5, 5, 10, 10));      // partial
        req_backlog.push_back(box_pair(0, 0, 3, 1, 0, 0, 1, 1));          // truncation
        req_backlog.push_back(box_pair(5, 5, 0, 10, 0, 0, 20, 20));       // zero width
        req_backlog.push_back(box_pair(0, 0, 10, 0, 0, 0, 10, 10));       // zero height
        req_backlog.push_back(box_pair(4095, 4095, 0, 0, 0, 0, 0, 0));    // two empty boxes
        req_backlog.push_back(box_pair(4095, 4095, 4095, 4095,
                                       4000, 4000, 4095, 4095));         // ends past range
        req_backlog.push_back(box_pair(0, 0, 4095, 4095, 4095, 0, 4095, 4095)); // touch at max
        req_backlog.push_back(box_pair(0, 0, 4095, 4095, 1, 1, 4095, 4095));
        req_backlog.push_back(box_pair(4095, 4095, 1, 1, 4095, 4095, 1, 1));
        req_backlog.push_back(box_pair(0, 0, 4095, 1, 0, 0, 1, 4095));    // thin cross
        req_backlog.push_back(box_pair('haaa, 'h555, 'haaa, 'h555,
                                       'h555, 'haaa, 'h555, 'haaa));
        req_backlog.push_back(box_pair('h555, 'haaa, 'h555, 'haaa,
                                       'haaa, 'h555, 'haaa, 'h555));

        // Random requests, mostly overlapping pairs so the divider sees
        // a wide spread of quotients rather than a stream of zeros.
        repeat (RANDOM_REQS)
        begin
            kind = $urandom_range(99);
            r.a_left   = coord_t'($urandom_range(0, 4095));
            r.a_top    = coord_t'($urandom_range(0, 4095));
            r.a_width  = rand_extent();
            r.a_height = rand_extent();
            r.b_width  = rand_extent();
            r.b_height = rand_extent();
            r.b_left   = r.a_left + coord_t'($urandom_range(0, 127)) - coord_t'(64);
            r.b_top    = r.a_top + coord_t'($urandom_range(0, 127)) - coord_t'(64);
            if (kind < 15)
            begin
                r = iou_req_t'({$urandom, $urandom, $urandom});
            end
            else if (kind < 65)
            begin
                // keep the nearby overlapping pair as drawn
            end
            else if (kind < 72)
            begin
                r.b_left   = r.a_left;
                r.b_top    = r.a_top;
                r.b_width  = r.a_width;
                r.b_height = r.a_height;
            end
            else if (kind < 80)
            begin
                // b's top-left corner within a, or b snug against a's right edge
                r.b_left = r.a_left + coord_t'($urandom_range(0, r.a_width));
                r.b_top  = r.a_top + coord_t'($urandom_range(0, r.a_height));
                if ($urandom_range(1) == 1)
                    r.b_left = r.a_left + r.a_width;
            end
            else if (kind < 90)
            begin
                if ($urandom_range(1) == 1) r.a_width  = '0;
                if ($urandom_range(1) == 1) r.a_height = '0;
                if ($urandom_range(1) == 1) r.b_width  = '0;
                if ($urandom_range(1) == 1) r.b_height = '0;
            end
            else
            begin
                r.a_width  = coord_t'($urandom_range(3800, 4095));
                r.a_height = coord_t'($urandom_range(3800, 4095));
                r.b_width  = coord_t'($urandom_range(3800, 4095));
                r.b_height = coord_t'($urandom_range(3800, 4095));
            end
            req_backlog.push_back(r);
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for the backlog to be taken, then for every response.
        while (req_backlog.size() != 0 || req_valid)
            @(posedge clk);
        while (scores_due.size() != 0)
            @(posedge clk);
        // Give a stray extra response time to show up.
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
